// ===== rtl/idl_pkg.sv =====
// Package for the indexed insert/delete list: field widths, operation and status codes,
// controller states and the command and status structs between controller and datapath.
// Used by idl_ctrl, idl_datapath and indexed_insert_delete_list_core.
`timescale 1ns / 1ps

package idl_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int OP_W         = 3;
    localparam int POS_W        = 6;
    localparam int WORD_W       = 32;
    localparam int ST_W         = 2;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_REMOVE = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_READ   = 3'd4,
        OP_CLEAR  = 3'd5
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT_UP,
        S_INS_LAST,
        S_SHIFT_DN,
        S_FETCH,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        A_ZERO,
        A_POS,
        A_LAST,
        A_POS_UP,
        A_IDX_DN,
        A_IDX_UP
    } t_asel;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LAST,
        IDX_POS_UP,
        IDX_DEC,
        IDX_INC
    } t_idx_op;

    typedef enum logic [1:0] {
        W_FILL,
        W_POS,
        W_IDX_UP,
        W_IDX_DN
    } t_wsel;

    typedef enum logic [1:0] {
        F_HOLD,
        F_INC,
        F_DEC,
        F_CLEAR
    } t_fill_op;

    typedef struct packed {
        logic     load;
        logic     status_en;
        t_status  status;
        logic     rd_a_en;
        t_asel    rd_a_sel;
        logic     rd_b_en;
        t_idx_op  idx_op;
        logic     wr_en;
        t_wsel    wr_sel;
        t_fill_op fill_op;
        logic     capture_rd;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_opcode op;
        logic    pos_ok;
        logic    pos_is_last;
        logic    full;
        logic    empty;
        logic    idx_at_pos;
        logic    idx_at_last;
        logic    out_free;
    } t_dp_sts;

endpackage

// ===== rtl/indexed_insert_delete_list_core.sv =====
// After acceptance a request runs through execute, any shift states and fetch; its result
// enters the output register once that register is free. Inserts and deletes move one
// entry per cycle through the single write port.
// o_stall stays high until the result is loaded, so the next request is taken after that.
// Reset (synchronous, active low) empties the list and invalidates the output register;
// the entry memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module indexed_insert_delete_list_core #(
    parameter  int CAPACITY = idl_pkg::CAPACITY_DEF,
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [idl_pkg::OP_W-1:0]          i_opcode,
    input  logic [idl_pkg::POS_W-1:0]         i_position,
    input  logic signed [idl_pkg::WORD_W-1:0] i_word_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [idl_pkg::ST_W-1:0]          o_status,
    output logic signed [idl_pkg::WORD_W-1:0] o_read_word,
    output logic [CW-1:0]                     o_count,
    output logic signed [idl_pkg::WORD_W-1:0] o_first_word,
    output logic signed [idl_pkg::WORD_W-1:0] o_last_word
);

    idl_pkg::t_dp_cmd cmd;
    idl_pkg::t_dp_sts sts;

    idl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    idl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_opcode     (i_opcode),
        .i_position   (i_position),
        .i_word_in    (i_word_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_read_word  (o_read_word),
        .o_count      (o_count),
        .o_first_word (o_first_word),
        .o_last_word  (o_last_word),
        .i_cmd        (cmd),
        .o_sts        (sts)
    );

endmodule

// ===== rtl/idl_ctrl.sv =====
// Controller state machine for the indexed insert/delete list.
// Sequences each request through the datapath by commands; depends on idl_pkg.
`timescale 1ns / 1ps

module idl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  idl_pkg::t_dp_sts  i_sts,
    output idl_pkg::t_dp_cmd  o_cmd
);

    idl_pkg::t_state r_state;
    idl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= idl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.status     = idl_pkg::ST_OK;
        o_cmd.rd_a_sel   = idl_pkg::A_ZERO;
        o_cmd.idx_op     = idl_pkg::IDX_HOLD;
        o_cmd.wr_sel     = idl_pkg::W_FILL;
        o_cmd.fill_op    = idl_pkg::F_HOLD;
        o_stall          = (r_state != idl_pkg::S_IDLE);

        case (r_state)
            idl_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = idl_pkg::S_EXEC;
                end
            end
            idl_pkg::S_EXEC: begin
                o_cmd.status_en = 1'b1;
                n_state         = idl_pkg::S_FETCH;
                case (i_sts.op)
                    idl_pkg::OP_APPEND: begin
                        if (i_sts.full) begin
                            o_cmd.status = idl_pkg::ST_FULL;
                        end else begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_sel  = idl_pkg::W_FILL;
                            o_cmd.fill_op = idl_pkg::F_INC;
                        end
                    end
                    idl_pkg::OP_REMOVE: begin
                        if (i_sts.empty) begin
                            o_cmd.status = idl_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.fill_op = idl_pkg::F_DEC;
                        end
                    end
                    idl_pkg::OP_INSERT: begin
                        if (!i_sts.pos_ok) begin
                            o_cmd.status = idl_pkg::ST_RANGE;
                        end else if (i_sts.full) begin
                            o_cmd.status = idl_pkg::ST_FULL;
                        end else begin
                            o_cmd.rd_a_en  = 1'b1;
                            o_cmd.rd_a_sel = idl_pkg::A_LAST;
                            o_cmd.idx_op   = idl_pkg::IDX_LAST;
                            n_state        = idl_pkg::S_SHIFT_UP;
                        end
                    end
                    idl_pkg::OP_DELETE: begin
                        if (!i_sts.pos_ok) begin
                            o_cmd.status = idl_pkg::ST_RANGE;
                        end else if (i_sts.pos_is_last) begin
                            o_cmd.fill_op = idl_pkg::F_DEC;
                        end else begin
                            o_cmd.rd_a_en  = 1'b1;
                            o_cmd.rd_a_sel = idl_pkg::A_POS_UP;
                            o_cmd.idx_op   = idl_pkg::IDX_POS_UP;
                            n_state        = idl_pkg::S_SHIFT_DN;
                        end
                    end
                    idl_pkg::OP_READ: begin
                        if (!i_sts.pos_ok) begin
                            o_cmd.status = idl_pkg::ST_RANGE;
                        end else begin
                            o_cmd.rd_a_en  = 1'b1;
                            o_cmd.rd_a_sel = idl_pkg::A_POS;
                        end
                    end
                    idl_pkg::OP_CLEAR: begin
                        o_cmd.fill_op = idl_pkg::F_CLEAR;
                    end
                    default: begin
                    end
                endcase
            end
            idl_pkg::S_SHIFT_UP: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = idl_pkg::W_IDX_UP;
                if (i_sts.idx_at_pos) begin
                    n_state = idl_pkg::S_INS_LAST;
                end else begin
                    o_cmd.rd_a_en  = 1'b1;
                    o_cmd.rd_a_sel = idl_pkg::A_IDX_DN;
                    o_cmd.idx_op   = idl_pkg::IDX_DEC;
                end
            end
            idl_pkg::S_INS_LAST: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = idl_pkg::W_POS;
                o_cmd.fill_op = idl_pkg::F_INC;
                n_state       = idl_pkg::S_FETCH;
            end
            idl_pkg::S_SHIFT_DN: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = idl_pkg::W_IDX_DN;
                if (i_sts.idx_at_last) begin
                    o_cmd.fill_op = idl_pkg::F_DEC;
                    n_state       = idl_pkg::S_FETCH;
                end else begin
                    o_cmd.rd_a_en  = 1'b1;
                    o_cmd.rd_a_sel = idl_pkg::A_IDX_UP;
                    o_cmd.idx_op   = idl_pkg::IDX_INC;
                end
            end
            idl_pkg::S_FETCH: begin
                o_cmd.capture_rd = 1'b1;
                o_cmd.rd_a_en    = 1'b1;
                o_cmd.rd_a_sel   = idl_pkg::A_ZERO;
                o_cmd.rd_b_en    = 1'b1;
                n_state          = idl_pkg::S_DONE;
            end
            idl_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = idl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = idl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/idl_datapath.sv =====
// Datapath for the indexed insert/delete list: entry memory, fill count, shift index,
// request and result registers. Driven by idl_ctrl commands; depends on idl_pkg.
`timescale 1ns / 1ps

module idl_datapath #(
    parameter  int CAPACITY = idl_pkg::CAPACITY_DEF,
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [idl_pkg::OP_W-1:0]         i_opcode,
    input  logic [idl_pkg::POS_W-1:0]        i_position,
    input  logic signed [idl_pkg::WORD_W-1:0] i_word_in,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [idl_pkg::ST_W-1:0]         o_status,
    output logic signed [idl_pkg::WORD_W-1:0] o_read_word,
    output logic [CW-1:0]                    o_count,
    output logic signed [idl_pkg::WORD_W-1:0] o_first_word,
    output logic signed [idl_pkg::WORD_W-1:0] o_last_word,
    input  idl_pkg::t_dp_cmd                 i_cmd,
    output idl_pkg::t_dp_sts                 o_sts
);

    localparam int AW = $clog2(CAPACITY);
    localparam int XW = (CW > idl_pkg::POS_W) ? CW : idl_pkg::POS_W;

    logic [idl_pkg::WORD_W-1:0] r_mem [CAPACITY];

    idl_pkg::t_opcode           r_op;
    logic [XW-1:0]              r_pos;
    logic [idl_pkg::WORD_W-1:0] r_word;
    logic [CW-1:0]              r_fill;
    logic [CW-1:0]              n_fill;
    logic [AW-1:0]              r_idx;
    logic [AW-1:0]              n_idx;
    idl_pkg::t_status           r_status;
    logic [idl_pkg::WORD_W-1:0] r_rdata_a;
    logic [idl_pkg::WORD_W-1:0] r_rdata_b;
    logic [idl_pkg::WORD_W-1:0] r_read_word;
    logic                       r_out_valid;
    logic [idl_pkg::ST_W-1:0]   r_out_status;
    logic [idl_pkg::WORD_W-1:0] r_out_read;
    logic [CW-1:0]              r_out_count;
    logic [idl_pkg::WORD_W-1:0] r_out_first;
    logic [idl_pkg::WORD_W-1:0] r_out_last;

    logic [CW-1:0]              fill_last;
    logic [AW-1:0]              last_addr;
    logic [AW-1:0]              pos_addr;
    logic [AW-1:0]              rd_addr_a;
    logic [AW-1:0]              wr_addr;
    logic [idl_pkg::WORD_W-1:0] wr_data;
    logic                       out_free;

    assign fill_last = r_fill - CW'(1);
    assign last_addr = fill_last[AW-1:0];
    assign pos_addr  = r_pos[AW-1:0];
    assign out_free  = !r_out_valid || !i_stall;

    always_comb begin
        case (i_cmd.rd_a_sel)
            idl_pkg::A_POS:    rd_addr_a = pos_addr;
            idl_pkg::A_LAST:   rd_addr_a = last_addr;
            idl_pkg::A_POS_UP: rd_addr_a = pos_addr + AW'(1);
            idl_pkg::A_IDX_DN: rd_addr_a = r_idx - AW'(1);
            idl_pkg::A_IDX_UP: rd_addr_a = r_idx + AW'(1);
            default:           rd_addr_a = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.wr_sel)
            idl_pkg::W_FILL: begin
                wr_addr = r_fill[AW-1:0];
                wr_data = r_word;
            end
            idl_pkg::W_POS: begin
                wr_addr = pos_addr;
                wr_data = r_word;
            end
            idl_pkg::W_IDX_UP: begin
                wr_addr = r_idx + AW'(1);
                wr_data = r_rdata_a;
            end
            default: begin
                wr_addr = r_idx - AW'(1);
                wr_data = r_rdata_a;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.idx_op)
            idl_pkg::IDX_LAST:   n_idx = last_addr;
            idl_pkg::IDX_POS_UP: n_idx = pos_addr + AW'(1);
            idl_pkg::IDX_DEC:    n_idx = r_idx - AW'(1);
            idl_pkg::IDX_INC:    n_idx = r_idx + AW'(1);
            default:             n_idx = r_idx;
        endcase
    end

    always_comb begin
        case (i_cmd.fill_op)
            idl_pkg::F_INC:   n_fill = r_fill + CW'(1);
            idl_pkg::F_DEC:   n_fill = fill_last;
            idl_pkg::F_CLEAR: n_fill = '0;
            default:          n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_a_en) begin
            r_rdata_a <= r_mem[rd_addr_a];
        end
        if (i_cmd.rd_b_en) begin
            r_rdata_b <= r_mem[last_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load) begin
            r_op   <= idl_pkg::t_opcode'(i_opcode);
            r_pos  <= XW'(i_position);
            r_word <= i_word_in;
        end
        if (i_cmd.status_en) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.capture_rd) begin
            r_read_word <= (r_op == idl_pkg::OP_READ && r_status == idl_pkg::ST_OK)
                           ? r_rdata_a : '0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_read   <= r_read_word;
            r_out_count  <= r_fill;
            r_out_first  <= (r_fill != '0) ? r_rdata_a : '0;
            r_out_last   <= (r_fill != '0) ? r_rdata_b : '0;
        end
    end

    assign o_sts.op          = r_op;
    assign o_sts.pos_ok      = r_pos < XW'(r_fill);
    assign o_sts.pos_is_last = r_pos == XW'(fill_last);
    assign o_sts.full        = r_fill == CW'(CAPACITY);
    assign o_sts.empty       = r_fill == '0;
    assign o_sts.idx_at_pos  = r_idx == pos_addr;
    assign o_sts.idx_at_last = r_idx == last_addr;
    assign o_sts.out_free    = out_free;

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_word  = r_out_read;
    assign o_count      = r_out_count;
    assign o_first_word = r_out_first;
    assign o_last_word  = r_out_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(CAPACITY))
        else $error("Fill count exceeds capacity.");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("Result loaded over one not yet taken.");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_en && i_cmd.rd_a_en) |-> (wr_addr != rd_addr_a))
        else $error("Shift reads and writes the same entry in one cycle.");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == idl_pkg::ST_EMPTY) |-> (r_out_count == '0))
        else $error("Empty status with entries held.");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == idl_pkg::ST_FULL) |-> (r_out_count == CW'(CAPACITY)))
        else $error("Full status below capacity.");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for indexed_insert_delete_list_core: a directed table and a long
// random run of list requests, each checked against a table result or an in-bench model
// of the ordered store. Depends on idl_pkg and indexed_insert_delete_list_core.
`timescale 1ns / 1ps

module tb_top;
    import idl_pkg::*;

    localparam int LIST_CAP     = CAPACITY_DEF;
    localparam int CNT_W        = $clog2(LIST_CAP + 1);
    localparam int IDLE_PCT     = 18;
    localparam int RANDOM_ITEMS = 1660;
    localparam int QUIET_FIRST  = 700;
    localparam int QUIET_LAST   = 999;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 250;
    localparam int PAUSE_AT     = 1100;
    localparam int TAIL_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 1000000;

    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        t_status                  status;
        logic signed [WORD_W-1:0] read_word;
        logic [CNT_W-1:0]         count;
        logic signed [WORD_W-1:0] first_word;
        logic signed [WORD_W-1:0] last_word;
    } t_list_result;

    typedef struct {
        logic [OP_W-1:0]          opcode;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] word;
        int                       reps;
        bit                       typed;
        t_list_result             result;
    } t_stim_row;

    logic                     i_clk;
    logic                     i_rst_n    = 1'b0;
    logic                     i_valid    = 1'b0;
    logic [OP_W-1:0]          i_opcode   = '0;
    logic [POS_W-1:0]         i_position = '0;
    logic signed [WORD_W-1:0] i_word_in  = '0;
    logic                     i_stall    = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic [ST_W-1:0]          o_status;
    logic signed [WORD_W-1:0] o_read_word;
    logic [CNT_W-1:0]         o_count;
    logic signed [WORD_W-1:0] o_first_word;
    logic signed [WORD_W-1:0] o_last_word;

    logic signed [WORD_W-1:0] list_words [LIST_CAP];
    int                       list_len;
    t_list_result             pending_results [$];
    t_stim_row                stim_rows [$];
    t_list_result             oldest;

    bit quiet_mode  = 1'b0;
    int hold_orders = 0;
    int cycle_count = 0;
    int error_count = 0;
    int requests_sent, results_checked, peak_len, full_hits, range_hits, empty_hits;

    indexed_insert_delete_list_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_position   (i_position),
        .i_word_in    (i_word_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_read_word  (o_read_word),
        .o_count      (o_count),
        .o_first_word (o_first_word),
        .o_last_word  (o_last_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_list_result apply_list_op(input logic [OP_W-1:0] opcode,
                                                   input logic [POS_W-1:0] position,
                                                   input logic signed [WORD_W-1:0] word);
        t_list_result r;
        int           idx;
        int           i;
        idx         = int'(position);
        r.status    = ST_OK;
        r.read_word = '0;
        case (opcode)
            OP_APPEND: begin
                if (list_len >= LIST_CAP) begin
                    r.status = ST_FULL;
                end else begin
                    list_words[list_len] = word;
                    list_len++;
                end
            end
            OP_REMOVE: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else list_len--;
            end
            OP_INSERT: begin
                if (idx >= list_len) begin
                    r.status = ST_RANGE;
                end else if (list_len >= LIST_CAP) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_len; i > idx; i--) list_words[i] = list_words[i-1];
                    list_words[idx] = word;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (idx >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = idx; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            OP_READ: begin
                if (idx >= list_len) r.status = ST_RANGE;
                else r.read_word = list_words[idx];
            end
            OP_CLEAR: list_len = 0;
            default: ;
        endcase
        r.count      = CNT_W'(list_len);
        r.first_word = (list_len > 0) ? list_words[0] : '0;
        r.last_word  = (list_len > 0) ? list_words[list_len-1] : '0;
        return r;
    endfunction

    function automatic void add_row(input logic [OP_W-1:0] opcode,
                                    input logic [POS_W-1:0] position,
                                    input logic signed [WORD_W-1:0] word,
                                    input int reps, input bit typed,
                                    input t_list_result result);
        t_stim_row row;
        row.opcode   = opcode;
        row.position = position;
        row.word     = word;
        row.reps     = reps;
        row.typed    = typed;
        row.result   = result;
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    task automatic issue_request(input logic [OP_W-1:0] opcode,
                                 input logic [POS_W-1:0] position,
                                 input logic signed [WORD_W-1:0] word,
                                 input bit typed, input t_list_result typed_result);
        t_list_result predicted;
        while (!quiet_mode && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_opcode   <= opcode;
        i_position <= position;
        i_word_in  <= word;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = apply_list_op(opcode, position, word);
        pending_results.insert(pending_results.size(), typed ? typed_result : predicted);
        requests_sent++;
        if (list_len > peak_len) peak_len = list_len;
        case (predicted.status)
            ST_FULL:  full_hits++;
            ST_RANGE: range_hits++;
            ST_EMPTY: empty_hits++;
            default: ;
        endcase
    endtask

    task automatic wait_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic compare_field(input string name, input logic [WORD_W-1:0] expected,
                                 input logic [WORD_W-1:0] actual);
        if (actual !== expected) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, expected, actual);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result returned with no request outstanding");
                error_count++;
            end else begin
                oldest = pending_results.pop_front();
                results_checked++;
                compare_field("status", WORD_W'(oldest.status), WORD_W'(o_status));
                compare_field("read_word", oldest.read_word, o_read_word);
                compare_field("count", WORD_W'(oldest.count), WORD_W'(o_count));
                compare_field("first_word", oldest.first_word, o_first_word);
                compare_field("last_word", oldest.last_word, o_last_word);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : receiver
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (holds_served != hold_orders) begin
                holds_served++;
                hold_left = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else if (quiet_mode) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    initial begin : stimulus
        t_stim_row                row;
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         pos;
        logic signed [WORD_W-1:0] word;
        int                       target;
        int                       r;
        int                       directed_count;

        list_len = 0;
        foreach (list_words[i]) list_words[i] = '0;

        add_row(OP_REMOVE, 0, 0, 1, 1, '{ST_EMPTY, 32'sd0, '0, 32'sd0, 32'sd0});
        add_row(OP_READ, 0, 0, 1, 1, '{ST_RANGE, 32'sd0, '0, 32'sd0, 32'sd0});
        add_row(OP_INSERT, 0, 32'sh1234_5678, 1, 1, '{ST_RANGE, 32'sd0, '0, 32'sd0, 32'sd0});
        add_row(OP_DELETE, 63, 0, 1, 1, '{ST_RANGE, 32'sd0, '0, 32'sd0, 32'sd0});
        add_row(OP_SPARE_A, 0, 0, 1, 1, '{ST_OK, 32'sd0, '0, 32'sd0, 32'sd0});
        add_row(OP_SPARE_B, 63, -1, 1, 1, '{ST_OK, 32'sd0, '0, 32'sd0, 32'sd0});
        add_row(OP_APPEND, 0, WORD_MAX, 1, 1, '{ST_OK, 32'sd0, 7'd1, WORD_MAX, WORD_MAX});
        add_row(OP_APPEND, 63, WORD_MIN, 1, 1, '{ST_OK, 32'sd0, 7'd2, WORD_MAX, WORD_MIN});
        add_row(OP_INSERT, 0, -1, 1, 0, '0);
        add_row(OP_INSERT, 1, 32'sh5555_5555, 1, 0, '0);
        add_row(OP_READ, 1, 0, 1, 0, '0);
        add_row(OP_READ, 63, 0, 1, 0, '0);
        add_row(OP_DELETE, 0, 0, 1, 0, '0);
        add_row(OP_DELETE, 2, 0, 1, 0, '0);
        add_row(OP_INSERT, 2, 32'shAAAA_AAAA, 1, 0, '0);
        add_row(OP_READ, 0, 0, 1, 0, '0);
        add_row(OP_CLEAR, 0, 0, 1, 1, '{ST_OK, 32'sd0, '0, 32'sd0, 32'sd0});
        add_row(OP_CLEAR, 0, 0, 1, 1, '{ST_OK, 32'sd0, '0, 32'sd0, 32'sd0});
        add_row(OP_APPEND, 0, 32'sh0F00_0000, LIST_CAP, 0, '0);
        add_row(OP_APPEND, 0, WORD_MIN, 1, 0, '0);
        add_row(OP_INSERT, 5, WORD_MAX, 1, 0, '0);
        add_row(OP_READ, 63, 0, 1, 0, '0);
        add_row(OP_DELETE, 63, 0, 1, 0, '0);
        add_row(OP_INSERT, 62, 32'sh3C3C_3C3C, 1, 0, '0);
        add_row(OP_REMOVE, 0, 0, 1, 0, '0);
        add_row(OP_CLEAR, 0, 0, 1, 1, '{ST_OK, 32'sd0, '0, 32'sd0, 32'sd0});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[n]) begin
            row = stim_rows[n];
            for (int k = 0; k < row.reps; k++)
                issue_request(row.opcode, row.position, row.word + k, row.typed, row.result);
        end
        directed_count = requests_sent;
        wait_until_drained();

        target = 0;
        for (int item = 0; item < RANDOM_ITEMS; item++) begin
            if (item == QUIET_FIRST) quiet_mode <= 1'b1;
            if (item == QUIET_LAST) quiet_mode <= 1'b0;
            if (item == HOLD_AT) hold_orders <= hold_orders + 1;
            if (item == PAUSE_AT) wait_until_drained();

            if (item % 40 == 0) begin
                r = $urandom_range(0, 99);
                if (r < 75) target = $urandom_range(0, 12);
                else if (r < 95) target = $urandom_range(13, 50);
                else target = LIST_CAP + 2;
            end

            r = $urandom_range(0, 99);
            if (r < 2) begin
                op = ($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B;
            end else if (r < 4) begin
                op = OP_CLEAR;
            end else begin
                r = $urandom_range(0, 99);
                if (list_len < target) begin
                    if (r < 50) op = OP_APPEND;
                    else if (r < 75) op = OP_INSERT;
                    else if (r < 85) op = OP_READ;
                    else if (r < 92) op = OP_DELETE;
                    else op = OP_REMOVE;
                end else begin
                    if (r < 5) op = OP_APPEND;
                    else if (r < 30) op = OP_REMOVE;
                    else if (r < 55) op = OP_DELETE;
                    else if (r < 80) op = OP_READ;
                    else op = OP_INSERT;
                end
            end

            if (list_len > 0 && $urandom_range(0, 99) < 85)
                pos = POS_W'($urandom_range(0, list_len - 1));
            else
                pos = POS_W'($urandom_range(0, 63));

            case ($urandom_range(0, 39))
                0: word = WORD_MAX;
                1: word = WORD_MIN;
                2: word = '0;
                3: word = -1;
                default: word = $urandom;
            endcase

            issue_request(op, pos, word, 1'b0, '0);
        end

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d list requests (%0d from the directed table), checked %0d results.",
                 requests_sent, directed_count, results_checked);
        $display("Peak length %0d; %0d full, %0d out-of-range and %0d empty rejections seen.",
                 peak_len, full_hits, range_hits, empty_hits);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
